>>> src/caf_pkg.sv
// caf_pkg: shared constants, types and state codes for the can acceptance filter
// no dependencies
`timescale 1ns / 1ps

package caf_pkg;

  // filter bank size
  localparam int NUM_ENTRIES = 32;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

  // field widths
  localparam int ID_W    = 11;
  localparam int EIDX_W  = 8;
  localparam int MIDX_W  = 5;
  localparam int CFG_W   = 6;
  localparam int CMP_W   = 10;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_ENTRIES_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0]   RESET_IN_USE       = CFG_W'(32);

  // item function codes
  localparam logic FUNC_CONFIG = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_IDX = 1'b1;

  // one stored filter entry; the rtr bit is always compared
  typedef struct packed {
    logic            handler;
    logic            rtr;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] mask;
  } entry_t;

  // a never-written entry matches only identifier 0 without rtr, no handler
  localparam entry_t ENTRY_RESET = '{handler: 1'b0, rtr: 1'b0, id: '0, mask: '1};

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CFG,
    ST_SCAN
  } state_t;

endpackage

>>> src/caf_entry_ram.sv
// caf_entry_ram: filter entry memory, one write and one registered read port
// per-entry valid bits substitute the reset entry until written; uses caf_pkg
`timescale 1ns / 1ps

module caf_entry_ram
  import caf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  ram_wr_t wr,
  input  ram_rd_t rd,
  output entry_t  rd_data
);

  entry_t                 mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_r;
  entry_t                 rd_data_r;
  logic                   rd_vld_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld_r <= valid_r[rd.addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : ENTRY_RESET;

endmodule

>>> src/caf_ctrl.sv
// caf_ctrl: item sequencer; writes entries and scans the bank for a lookup
// uses caf_pkg; drives caf_entry_ram through write and read request structs
`timescale 1ns / 1ps

module caf_ctrl
  import caf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CNT_W-1:0]   active_cnt,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [EIDX_W-1:0]  in_entry_index,
  input  logic [ID_W-1:0]    in_can_id,
  input  logic [ID_W-1:0]    in_id_mask,
  input  logic               in_rtr,
  input  logic               in_has_handler,
  output ram_wr_t            ram_wr,
  output ram_rd_t            ram_rd,
  input  entry_t             ram_rdata,
  output logic               out_valid,
  output logic               out_status,
  output logic               out_matched,
  output logic               out_delivered,
  output logic [MIDX_W-1:0]  out_match_index
);

  state_t state_r, state_nxt;

  // latched item
  logic              func_r;
  logic [EIDX_W-1:0] eidx_r;
  logic [ID_W-1:0]   id_r;
  logic [ID_W-1:0]   mask_r;
  logic              rtr_r;
  logic              hnd_r;

  // scan pipeline
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  // result registers
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_matched_r, out_matched_nxt;
  logic              out_delivered_r, out_delivered_nxt;
  logic [MIDX_W-1:0] out_midx_r, out_midx_nxt;

  logic                    accept;
  logic                    legal;
  logic                    hit;
  logic                    finish;
  logic [IDX_W+MIDX_W-1:0] midx_ext;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // index check and entry compare
  assign legal = (CMP_W'(eidx_r) < CMP_W'(active_cnt));
  assign hit   = cmp_vld_r && (ram_rdata.rtr == rtr_r) &&
                 (((id_r ^ ram_rdata.id) & ram_rdata.mask) == '0);
  assign finish   = hit || (CMP_W'(iss_r) >= CMP_W'(active_cnt));
  assign midx_ext = {{MIDX_W{1'b0}}, cmp_idx_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_func == FUNC_LOOKUP) ? ST_SCAN : ST_CFG;
        end
      end
      ST_CFG: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // memory requests, scan pointers and result values
  always_comb begin
    ram_wr.en         = 1'b0;
    ram_wr.addr       = eidx_r[IDX_W-1:0];
    ram_wr.data       = '{handler: hnd_r, rtr: rtr_r, id: id_r, mask: mask_r};
    ram_rd.en         = 1'b0;
    ram_rd.addr       = iss_r[IDX_W-1:0];
    iss_nxt           = iss_r;
    cmp_vld_nxt       = 1'b0;
    cmp_idx_nxt       = cmp_idx_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = STATUS_OK;
    out_matched_nxt   = 1'b0;
    out_delivered_nxt = 1'b0;
    out_midx_nxt      = '0;
    unique case (state_r)
      ST_IDLE: begin
        iss_nxt = '0;
      end
      ST_CFG: begin
        ram_wr.en      = legal;
        out_valid_nxt  = 1'b1;
        out_status_nxt = legal ? STATUS_OK : STATUS_BAD_IDX;
      end
      ST_SCAN: begin
        if (finish) begin
          out_valid_nxt     = 1'b1;
          out_matched_nxt   = hit;
          out_delivered_nxt = hit && ram_rdata.handler;
          out_midx_nxt      = hit ? midx_ext[MIDX_W-1:0] : '0;
        end else begin
          ram_rd.en   = 1'b1;
          iss_nxt     = iss_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_r[IDX_W-1:0];
        end
      end
      default: begin
        iss_nxt = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      eidx_r <= in_entry_index;
      id_r   <= in_can_id;
      mask_r <= in_id_mask;
      rtr_r  <= in_rtr;
      hnd_r  <= in_has_handler;
    end
    cmp_idx_r       <= cmp_idx_nxt;
    out_status_r    <= out_status_nxt;
    out_matched_r   <= out_matched_nxt;
    out_delivered_r <= out_delivered_nxt;
    out_midx_r      <= (func_r == FUNC_LOOKUP) ? out_midx_nxt : '0;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_matched     = out_matched_r;
  assign out_delivered   = out_delivered_r;
  assign out_match_index = out_midx_r;

endmodule

>>> src/can_rx_acceptance_filter.sv
// can_rx_acceptance_filter: can receive acceptance filter bank, top level
// configure: writes the entry when its index is in use, else reports a bad index;
// lookup: scans the entry memory one read a cycle from entry 0 and stops at the
// first hit or after the entries in use; one item at a time, busy high while an
// item is at work; results cannot be stalled
// synchronous active-low reset: entries read as reset entries, entries_in_use = 32
`timescale 1ns / 1ps

module can_rx_acceptance_filter
  import caf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [EIDX_W-1:0]  in_entry_index,
  input  logic [ID_W-1:0]    in_can_id,
  input  logic [ID_W-1:0]    in_id_mask,
  input  logic               in_rtr,
  input  logic               in_has_handler,
  // result channel
  output logic               out_valid,
  output logic               out_status,
  output logic               out_matched,
  output logic               out_delivered,
  output logic [MIDX_W-1:0]  out_match_index,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CFG_W-1:0] cfg_in_use_r, cfg_in_use_nxt;
  logic             cfg_wr;
  logic [CMP_W-1:0] cnt_ext;
  logic [CNT_W-1:0] active_cnt;
  ram_wr_t          ram_wr;
  ram_rd_t          ram_rd;
  entry_t           ram_rdata;

  assign pready = 1'b1;

  // register write transfer
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE);
  assign cfg_in_use_nxt = cfg_wr ? pwdata[CFG_W-1:0] : cfg_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_in_use_r <= RESET_IN_USE;
    end else begin
      cfg_in_use_r <= cfg_in_use_nxt;
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE) begin
      prdata = PDATA_W'(cfg_in_use_r);
    end
  end

  // entries in use, saturated at the bank size
  assign cnt_ext    = (CMP_W'(cfg_in_use_r) > CMP_W'(NUM_ENTRIES)) ?
                      CMP_W'(NUM_ENTRIES) : CMP_W'(cfg_in_use_r);
  assign active_cnt = cnt_ext[CNT_W-1:0];

  caf_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .active_cnt      (active_cnt),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_can_id       (in_can_id),
    .in_id_mask      (in_id_mask),
    .in_rtr          (in_rtr),
    .in_has_handler  (in_has_handler),
    .ram_wr          (ram_wr),
    .ram_rd          (ram_rd),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_matched     (out_matched),
    .out_delivered   (out_delivered),
    .out_match_index (out_match_index)
  );

  caf_entry_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_rdata)
  );

endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking bench for the can receive acceptance filter bank
// drives filter writes and frame lookups plus apb register writes, checks every verdict
// depends on caf_pkg and can_rx_acceptance_filter
`timescale 1ns / 1ps

module testbench;
  import caf_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DIRECTED_ROWS   = 18;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 129;
  localparam int DRAIN_CYCLES    = NUM_ENTRIES + 8;
  localparam int MAX_REPORTS     = 10;

  localparam logic [PADDR_W-1:0] ADDR_IN_USE   = PADDR_W'({REG_ENTRIES_IN_USE, 2'b00});
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4);

  // directed rows either carry a typed-in verdict or defer to the predictor
  localparam logic GOLD      = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic              func;
    logic [EIDX_W-1:0] index;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   mask;
    logic              rtr;
    logic              handler;
  } frame_cmd_t;

  typedef struct packed {
    logic              status;
    logic              matched;
    logic              delivered;
    logic [MIDX_W-1:0] index;
  } verdict_t;

  typedef struct packed {
    frame_cmd_t cmd;
    logic       fixed;
    verdict_t   verdict;
  } directed_row_t;

  localparam verdict_t V_OK      = {STATUS_OK, 1'b0, 1'b0, MIDX_W'(0)};
  localparam verdict_t V_BAD_IDX = {STATUS_BAD_IDX, 1'b0, 1'b0, MIDX_W'(0)};

  logic clk;
  logic rst_n = 1'b0;

  // item channel drive
  logic       drive_start  = 1'b0;
  frame_cmd_t drive_cmd    = '0;
  logic       drive_fixed  = PREDICTED;
  verdict_t   drive_golden = V_OK;
  logic       busy;

  // result channel
  logic              out_valid;
  logic              out_status;
  logic              out_matched;
  logic              out_delivered;
  logic [MIDX_W-1:0] out_match_index;

  // configuration port
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // predictor state: its own copy of the bank and the entry count
  entry_t           filter_bank [NUM_ENTRIES];
  logic [CFG_W-1:0] entry_count;
  verdict_t         awaited_verdicts [$];

  logic idling_on = 1'b1;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   lookups_seen = 0, hits_seen = 0, handed_on = 0;
  int   writes_seen = 0, bad_writes = 0, settings_seen = 0;
  int   phase_count [N_PHASES] = '{32, 1, 0, 63, 33, 7, 31, 20};
  directed_row_t directed_table [DIRECTED_ROWS];

  can_rx_acceptance_filter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (drive_start),
    .busy            (busy),
    .in_func         (drive_cmd.func),
    .in_entry_index  (drive_cmd.index),
    .in_can_id       (drive_cmd.id),
    .in_id_mask      (drive_cmd.mask),
    .in_rtr          (drive_cmd.rtr),
    .in_has_handler  (drive_cmd.handler),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_matched     (out_matched),
    .out_delivered   (out_delivered),
    .out_match_index (out_match_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               awaited_verdicts.size());
      $display("tb: failure");
      $finish;
    end
  end

  // counts above the bank size saturate
  function automatic int active_entries();
    return (int'(entry_count) > NUM_ENTRIES) ? NUM_ENTRIES : int'(entry_count);
  endfunction

  // predicted verdict for one item, updating the bank on a filter write
  function automatic verdict_t apply_to_bank(frame_cmd_t cmd);
    verdict_t v;
    int       n;
    v = V_OK;
    n = active_entries();
    if (cmd.func == FUNC_CONFIG) begin
      if (int'(cmd.index) < n) begin
        filter_bank[cmd.index].handler = cmd.handler;
        filter_bank[cmd.index].rtr     = cmd.rtr;
        filter_bank[cmd.index].id      = cmd.id;
        filter_bank[cmd.index].mask    = cmd.mask;
      end else begin
        v.status = STATUS_BAD_IDX;
      end
    end else begin
      // first entry in use whose compared bits agree wins; rtr always compared
      for (int i = 0; i < n && !v.matched; i++) begin
        if (filter_bank[i].rtr == cmd.rtr &&
            ((filter_bank[i].id ^ cmd.id) & filter_bank[i].mask) == '0) begin
          v.matched   = 1'b1;
          v.delivered = filter_bank[i].handler;
          v.index     = MIDX_W'(i);
        end
      end
    end
    return v;
  endfunction

  function automatic frame_cmd_t filter_write(int idx, int id, int mask, logic rtr, logic hnd);
    return {FUNC_CONFIG, EIDX_W'(idx), ID_W'(id), ID_W'(mask), rtr, hnd};
  endfunction

  // unused fields of a lookup carry junk on purpose
  function automatic frame_cmd_t frame_lookup(int id, logic rtr);
    return {FUNC_LOOKUP, EIDX_W'(8'hA5), ID_W'(id), ID_W'(11'h5A5), rtr, 1'b1};
  endfunction

  function automatic verdict_t hit(int idx, logic handed);
    return {STATUS_OK, 1'b1, handed, MIDX_W'(idx)};
  endfunction

  // random item, mostly aimed at stored filters so lookups reach deep entries
  function automatic frame_cmd_t random_cmd();
    frame_cmd_t c;
    entry_t     e;
    int         n, roll;
    n = active_entries();
    roll = $urandom_range(99);
    c.func    = 1'($urandom_range(1));
    c.index   = EIDX_W'($urandom);
    c.id      = ID_W'($urandom);
    c.mask    = ID_W'($urandom);
    c.rtr     = 1'($urandom_range(1));
    c.handler = 1'($urandom_range(1));
    if (c.func == FUNC_CONFIG) begin
      if (n > 0 && roll < 75) begin
        c.index = EIDX_W'($urandom_range(n - 1));
      end else if (roll < 90) begin
        c.index = EIDX_W'(n + $urandom_range(3));
      end
      if ($urandom_range(99) < 25) begin
        c.mask = '1;
      end else if ($urandom_range(99) < 10) begin
        c.mask = '0;
      end
    end else begin
      if (roll < 70) begin
        e = filter_bank[$urandom_range(NUM_ENTRIES - 1)];
        c.id = e.id ^ (ID_W'($urandom) & ~e.mask);
        if ($urandom_range(9) != 0) begin
          c.rtr = e.rtr;
        end
      end else if (roll < 80) begin
        c.id = '0;
      end
    end
    return c;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // result check, item transfer and register write, all seen at the rising edge
  always @(posedge clk) begin
    verdict_t got, want, calc;
    if (rst_n) begin
      if (out_valid) begin
        got = {out_status, out_matched, out_delivered, out_match_index};
        if (awaited_verdicts.size() == 0) begin
          note_mismatch($sformatf("unexpected result st=%0b m=%0b d=%0b idx=%0d",
                                  got.status, got.matched, got.delivered, got.index));
        end else begin
          want = awaited_verdicts.pop_front();
          if (got.status !== want.status || got.matched !== want.matched ||
              got.delivered !== want.delivered || got.index !== want.index) begin
            note_mismatch($sformatf(
              "verdict mismatch: expected st=%0d m=%0d d=%0d idx=%0d, got st=%0b m=%0b d=%0b idx=%0d",
              want.status, want.matched, want.delivered, want.index,
              got.status, got.matched, got.delivered, got.index));
          end
        end
      end
      if (drive_start && !busy) begin
        calc = apply_to_bank(drive_cmd);
        awaited_verdicts.push_back(drive_fixed ? drive_golden : calc);
        if (drive_cmd.func == FUNC_CONFIG) begin
          writes_seen++;
          if (calc.status == STATUS_BAD_IDX) bad_writes++;
        end else begin
          lookups_seen++;
          if (calc.matched) hits_seen++;
          if (calc.delivered) handed_on++;
        end
      end
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE) begin
        entry_count = pwdata[CFG_W-1:0];
        settings_seen++;
      end
    end
  end

  // sender: random idle cycles, then hold start until the transfer
  task automatic send_cmd(input logic use_random, input frame_cmd_t cmd, input logic fixed,
                          input verdict_t golden);
    @(negedge clk);
    while (idling_on && $urandom_range(99) < 24) begin
      drive_start = 1'b0;
      @(negedge clk);
    end
    drive_cmd    = use_random ? random_cmd() : cmd;
    drive_fixed  = fixed;
    drive_golden = golden;
    drive_start  = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic apb_transfer(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = write; paddr = addr; pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic check_entry_count();
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b0, ADDR_IN_USE, '0, rd);
    if (rd !== PDATA_W'(entry_count)) begin
      note_mismatch($sformatf("entries_in_use readback: expected %0d, got %0h",
                              entry_count, rd));
    end
  endtask

  // upper data bits are noise, only the low six bits are kept
  task automatic set_entry_count(int count);
    logic [PDATA_W-1:0] wd, rd;
    wd = $urandom;
    wd[CFG_W-1:0] = CFG_W'(count);
    apb_transfer(1'b1, ADDR_IN_USE, wd, rd);
    check_entry_count();
  endtask

  // stop sending and wait for every outstanding verdict
  task automatic settle();
    @(negedge clk);
    drive_start = 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [PDATA_W-1:0] rd;
    for (int i = 0; i < NUM_ENTRIES; i++) filter_bank[i] = ENTRY_RESET;
    entry_count = RESET_IN_USE;

    directed_table = '{
      // reset entries match identifier 0 without rtr only, no handler
      {frame_lookup(11'h000, 1'b0), GOLD, hit(0, 1'b0)},
      {frame_lookup(11'h000, 1'b1), GOLD, V_OK},
      {frame_lookup(11'h7FF, 1'b0), GOLD, V_OK},
      // index at and far beyond the entries in use
      {filter_write(32, 11'h7FF, 11'h7FF, 1'b1, 1'b1), GOLD, V_BAD_IDX},
      {filter_write(255, 11'h7FF, 11'h7FF, 1'b1, 1'b1), GOLD, V_BAD_IDX},
      {filter_write(31, 11'h7FF, 11'h7FF, 1'b1, 1'b1), GOLD, V_OK},
      {frame_lookup(11'h7FF, 1'b1), GOLD, hit(31, 1'b1)},
      // empty mask accepts any data frame
      {filter_write(0, 11'h123, 11'h000, 1'b0, 1'b1), GOLD, V_OK},
      {frame_lookup(11'h555, 1'b0), GOLD, hit(0, 1'b1)},
      {frame_lookup(11'h555, 1'b1), PREDICTED, V_OK},
      {filter_write(1, 11'h2AA, 11'h7F0, 1'b1, 1'b0), PREDICTED, V_OK},
      {frame_lookup(11'h2A5, 1'b1), PREDICTED, V_OK},
      {filter_write(0, 11'h7FF, 11'h7FF, 1'b0, 1'b0), PREDICTED, V_OK},
      {frame_lookup(11'h000, 1'b0), PREDICTED, V_OK},
      {frame_lookup(11'h7FF, 1'b0), PREDICTED, V_OK},
      {filter_write(5, 11'h400, 11'h400, 1'b0, 1'b1), PREDICTED, V_OK},
      {frame_lookup(11'h4AB, 1'b0), PREDICTED, V_OK},
      {frame_lookup(11'h000, 1'b1), PREDICTED, V_OK}
    };

    // synchronous reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows at the reset entry count
    check_entry_count();
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_cmd(1'b0, directed_table[r].cmd, directed_table[r].fixed,
               directed_table[r].verdict);
    end
    settle();

    // random phases, one entry-count setting each; phase 3 never idles
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 1) begin
        // unmapped register, must leave the count alone
        apb_transfer(1'b1, ADDR_UNMAPPED, PDATA_W'(5), rd);
        check_entry_count();
      end
      set_entry_count(phase_count[p]);
      idling_on = (p != 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 5 && k == ITEMS_PER_PHASE / 2) begin
          settle();
        end
        send_cmd(1'b1, '0, PREDICTED, V_OK);
      end
      settle();
    end

    // drain and look for stray results
    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d lookups (%0d matched, %0d delivered), %0d filter writes (%0d bad index)",
             lookups_seen, hits_seen, handed_on, writes_seen, bad_writes);
    $display("across %0d entry-count writes including empty, single and saturated banks, %0d mismatches",
             settings_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
